>>> rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the transitive closure engine
// Widths of the row and index fields, controller states and the command and
// status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tce_pkg;

	// Fixed field widths
	localparam int ROW_W            = 32;
	localparam int IDX_OUT_W        = 5;
	localparam int CFG_W            = 6;
	localparam int ROW_SLOTS        = 32;
	localparam int DEF_MAX_VERTICES = 32;

	// Controller states
	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_CLOSE = 3'b010,
		ST_EMIT  = 3'b100
	} tce_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // accept one adjacency row
		logic step;   // one closure pivot step
		logic emit;   // move one closure row into the output register
	} tce_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic load_last;  // the row now at the input is the final one
		logic k_last;     // current pivot is the final vertex
		logic emit_last;  // current emit row is the final one
		logic out_free;   // output register can take a new beat
	} tce_stat_t;

endpackage

>>> rtl/core/tce_if.sv
// ----------------------------------------------------------------------------
// tce_if: channel interfaces of the transitive closure engine
// Input rows, output closure rows and the vertex count write channel.
// ----------------------------------------------------------------------------
interface tce_in_if;
	import tce_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_bits;

	modport source (output valid, output row_bits, input ready);
	modport sink   (input valid, input row_bits, output ready);
endinterface

interface tce_out_if;
	import tce_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ROW_W-1:0]     closure_row_bits;
	logic [IDX_OUT_W-1:0] row_index;
	logic                 last_row;

	modport source (output valid, output closure_row_bits, output row_index,
		output last_row, input ready);
	modport sink   (input valid, input closure_row_bits, input row_index,
		input last_row, output ready);
endinterface

interface tce_cfg_if;
	import tce_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink   (input valid, input vertex_count, output ready);
endinterface

>>> rtl/core/tce_ctrl.sv
// ----------------------------------------------------------------------------
// tce_ctrl: sequencing of load, closure and emit phases
// One-hot state machine that issues datapath commands from its status.
// ----------------------------------------------------------------------------
module tce_ctrl
	import tce_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tce_stat_t stat,
	output tce_cmd_t  cmd
);

	tce_state_t state_q, state_d;

	// Commands
	always_comb begin
		in_ready = (state_q == ST_LOAD);
		cmd.load = in_ready && in_valid;
		cmd.step = (state_q == ST_CLOSE);
		cmd.emit = (state_q == ST_EMIT) && stat.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (cmd.load && stat.load_last) state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				if (stat.k_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit && stat.emit_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// Final row loaded starts the closure
	a_load_to_close: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && stat.load_last) |=> (state_q == ST_CLOSE))
		else $error("final row did not start closure");

	// Last pivot hands over to emit
	a_close_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE && stat.k_last) |=> (state_q == ST_EMIT))
		else $error("closure did not end after last pivot");

	// No row taken while closing or emitting
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.emit) |-> !cmd.load)
		else $error("row accepted while busy");

endmodule

>>> rtl/core/tce_dp.sv
// ----------------------------------------------------------------------------
// tce_dp: matrix storage, counters and output register
// Holds the reachability rows, runs one pivot per step over all rows at once
// and stages closure rows for the output channel.
// ----------------------------------------------------------------------------
module tce_dp
	import tce_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tce_cmd_t             cmd,
	output tce_stat_t            stat,
	input  logic                 cfg_wr,
	input  logic [CFG_W-1:0]     cfg_vertex_count,
	input  logic [ROW_W-1:0]     in_row_bits,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [ROW_W-1:0]     out_row_bits,
	output logic [IDX_OUT_W-1:0] out_row_index,
	output logic                 out_last
);

	localparam int CAP   = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);
	localparam logic [CFG_W-1:0] CAP_CFG = CFG_W'(CAP);

	logic [ROW_W-1:0] reach_q [CAP];
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] load_cnt_q, k_q, emit_q;
	logic [CNT_W-1:0] n_m1;
	logic [ROW_W-1:0] mask, via;
	logic [IDX_W-1:0] rd_addr;
	logic [CFG_W-1:0] clamp_n;

	logic                 out_valid_q, last_q;
	logic [ROW_W-1:0]     row_q;
	logic [IDX_OUT_W-1:0] index_q;

	// Vertex count clamped to 1..CAP
	always_comb begin
		if (cfg_vertex_count == '0) clamp_n = CFG_W'(1);
		else if (cfg_vertex_count > CAP_CFG) clamp_n = CAP_CFG;
		else clamp_n = cfg_vertex_count;
	end

	// Row mask of active columns
	always_comb begin
		for (int j = 0; j < ROW_W; j++) mask[j] = (j < int'(n_q));
	end

	// Single read port: pivot row while closing, emit row otherwise
	assign rd_addr = cmd.step ? k_q : emit_q;
	assign via     = reach_q[rd_addr];
	assign n_m1    = n_q - CNT_W'(1);

	// Status
	always_comb begin
		stat.load_last = (CNT_W'(load_cnt_q) == n_m1);
		stat.k_last    = (CNT_W'(k_q) == n_m1);
		stat.emit_last = (CNT_W'(emit_q) == n_m1);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// Matrix rows: load one, or OR the pivot row into every row that reaches it
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reach_q[load_cnt_q] <= in_row_bits & mask;
		end else if (cmd.step) begin
			for (int i = 0; i < CAP; i++) begin
				if (reach_q[i][k_q]) reach_q[i] <= reach_q[i] | via;
			end
		end
	end

	// Vertex count and phase counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= CNT_W'(CAP);
			load_cnt_q <= '0;
			k_q        <= '0;
			emit_q     <= '0;
		end else begin
			if (cfg_wr) begin
				n_q        <= CNT_W'(clamp_n);
				load_cnt_q <= '0;
			end else if (cmd.load) begin
				load_cnt_q <= stat.load_last ? '0 : load_cnt_q + IDX_W'(1);
			end
			if (cmd.load) k_q <= '0;
			else if (cmd.step) k_q <= k_q + IDX_W'(1);
			if (cmd.load) emit_q <= '0;
			else if (cmd.emit) emit_q <= emit_q + IDX_W'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_q   <= via;
			index_q <= IDX_OUT_W'(emit_q);
			last_q  <= stat.emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row_bits  = row_q;
	assign out_row_index = index_q;
	assign out_last      = last_q;

endmodule

>>> rtl/core/transitive_closure_engine_top.sv
// ----------------------------------------------------------------------------
// transitive_closure_engine_top: Warshall transitive closure engine
// Loads an adjacency matrix row by row, closes it and returns closure rows.
// ----------------------------------------------------------------------------
// A matrix of N vertices (N from the vertex_count register, 0 read as 1 and
// values above the row capacity read as that capacity) is sent as N row beats,
// row 0 first, one beat per cycle. After the last row the engine closes the
// matrix, one pivot vertex per cycle with every row updated at once from the
// pivot row, then returns N closure rows at up to one beat per cycle, the
// final one flagged by last_row. Rows are not taken while closing or
// emitting; the next matrix may start loading while the final closure beat
// still waits at the output.
// Column bits at or above N are cleared on input and read as zero on output.
// Writing vertex_count drops any partly loaded matrix; write it only when idle.
module transitive_closure_engine_top
	import tce_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic      clk,
	input  logic      arst_n,
	tce_cfg_if.sink   cfg,
	tce_in_if.sink    rows,
	tce_out_if.source closure
);

	tce_cmd_t  cmd;
	tce_stat_t stat;

	assign cfg.ready = 1'b1;

	tce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rows.valid),
		.in_ready (rows.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tce_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_wr           (cfg.valid),
		.cfg_vertex_count (cfg.vertex_count),
		.in_row_bits      (rows.row_bits),
		.out_ready        (closure.ready),
		.out_valid        (closure.valid),
		.out_row_bits     (closure.closure_row_bits),
		.out_row_index    (closure.row_index),
		.out_last         (closure.last_row)
	);

endmodule
